FILE: src/tpi_pkg.sv
package tpi_pkg;

   localparam int NORMAL_FRAC_BITS = 14;

   // quotient bits produced by the divider, one per stage
   localparam int QUOT_BITS = 33;
   localparam int DIVD_W    = 64 + NORMAL_FRAC_BITS;
   localparam int HI_W      = DIVD_W - QUOT_BITS;
   localparam int REM_W     = 48;
   localparam int CROSS_W   = 33;
   localparam int DEN_W     = 51;
   localparam int NUM_W     = 67;

   typedef struct packed {
      logic signed [15:0] first_normal_x;
      logic signed [15:0] first_normal_y;
      logic signed [15:0] first_normal_z;
      logic signed [15:0] second_normal_x;
      logic signed [15:0] second_normal_y;
      logic signed [15:0] second_normal_z;
      logic signed [15:0] third_normal_x;
      logic signed [15:0] third_normal_y;
      logic signed [15:0] third_normal_z;
      logic signed [31:0] first_offset;
      logic signed [31:0] second_offset;
      logic signed [31:0] third_offset;
   } req_type;

   typedef struct packed {
      logic               found;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               saturated;
   } rsp_type;

endpackage

FILE: src/tpi_req_if.sv
interface tpi_req_if;
   logic              valid;
   logic              ready;
   tpi_pkg::req_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/tpi_rsp_if.sv
interface tpi_rsp_if;
   logic              valid;
   logic              ready;
   tpi_pkg::rsp_type  data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: src/three_plane_intersection.sv
// Common point of three planes n.x + d = 0 by Cramer's rule, normals Q2.14,
// offsets and coordinates Q16.16; the quotient truncates toward zero and each
// coordinate saturates to 32 bits (saturated flags it). A zero triple product
// gives found = 0 and all-zero fields. Fully pipelined: one word per cycle
// unless stalled; 6 stages (input register, products, sums, magnitudes), 33
// stages of a restoring divider producing one quotient bit each, and one
// output register. A stall on the response side holds the whole pipeline.
module three_plane_intersection (
   input  logic     clock,
   input  logic     reset,
   tpi_req_if.sink  req_chan,
   tpi_rsp_if.source rsp_chan
);

   localparam int QB = tpi_pkg::QUOT_BITS;
   localparam int RW = tpi_pkg::REM_W;

   logic adv;
   logic out_v_ff;
   tpi_pkg::rsp_type out_ff, out_in;

   assign adv            = !out_v_ff || rsp_chan.ready;
   assign req_chan.ready = adv;
   assign rsp_chan.valid = out_v_ff;
   assign rsp_chan.data  = out_ff;

   // stage 1: input register
   logic s1_v_ff;
   tpi_pkg::req_type s1_ff;
   logic signed [15:0] na [3];
   logic signed [15:0] nb [3];
   logic signed [15:0] nc [3];
   logic signed [31:0] dd [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_chan.valid;
      end
      if (adv) begin
         s1_ff <= req_chan.data;
      end
   end

   always_comb begin
      na[0] = s1_ff.first_normal_x;
      na[1] = s1_ff.first_normal_y;
      na[2] = s1_ff.first_normal_z;
      nb[0] = s1_ff.second_normal_x;
      nb[1] = s1_ff.second_normal_y;
      nb[2] = s1_ff.second_normal_z;
      nc[0] = s1_ff.third_normal_x;
      nc[1] = s1_ff.third_normal_y;
      nc[2] = s1_ff.third_normal_z;
      dd[0] = s1_ff.first_offset;
      dd[1] = s1_ff.second_offset;
      dd[2] = s1_ff.third_offset;
   end

   // stage 2: cross product terms, m = 0 bc, 1 ca, 2 ab
   logic s2_v_ff;
   logic signed [31:0] pr_ff [3][3][2];
   logic signed [31:0] pr_in [3][3][2];
   logic signed [15:0] a2_ff [3];
   logic signed [31:0] d2_ff [3];
   logic signed [31:0] d3_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pr_in[0][k][0] = nb[(k + 1) % 3] * nc[(k + 2) % 3];
         pr_in[0][k][1] = nb[(k + 2) % 3] * nc[(k + 1) % 3];
         pr_in[1][k][0] = nc[(k + 1) % 3] * na[(k + 2) % 3];
         pr_in[1][k][1] = nc[(k + 2) % 3] * na[(k + 1) % 3];
         pr_in[2][k][0] = na[(k + 1) % 3] * nb[(k + 2) % 3];
         pr_in[2][k][1] = na[(k + 2) % 3] * nb[(k + 1) % 3];
      end
   end

   // stage 3: cross products
   logic s3_v_ff;
   logic signed [tpi_pkg::CROSS_W-1:0] cr_ff [3][3];
   logic signed [15:0] a3_ff [3];

   // stage 4: products for triple product and numerators
   logic s4_v_ff;
   logic signed [48:0] dp_ff [3];
   logic signed [64:0] np_ff [3][3];

   // stage 5: sums
   logic s5_v_ff;
   logic signed [tpi_pkg::DEN_W-1:0] den_ff;
   logic signed [tpi_pkg::NUM_W-1:0] num_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
      if (adv) begin
         pr_ff <= pr_in;
         for (int k = 0; k < 3; k++) begin
            a2_ff[k] <= na[k];
            d2_ff[k] <= dd[k];
            a3_ff[k] <= a2_ff[k];
            d3_ff[k] <= d2_ff[k];
            for (int m = 0; m < 3; m++) begin
               cr_ff[m][k] <= tpi_pkg::CROSS_W'(pr_ff[m][k][0])
                            - tpi_pkg::CROSS_W'(pr_ff[m][k][1]);
            end
         end
         for (int k = 0; k < 3; k++) begin
            dp_ff[k] <= a3_ff[k] * cr_ff[0][k];
            for (int m = 0; m < 3; m++) begin
               np_ff[k][m] <= d3_ff[m] * cr_ff[m][k];
            end
         end
         den_ff <= tpi_pkg::DEN_W'(dp_ff[0]) + tpi_pkg::DEN_W'(dp_ff[1])
                 + tpi_pkg::DEN_W'(dp_ff[2]);
         for (int k = 0; k < 3; k++) begin
            num_ff[k] <= tpi_pkg::NUM_W'(np_ff[k][0]) + tpi_pkg::NUM_W'(np_ff[k][1])
                       + tpi_pkg::NUM_W'(np_ff[k][2]);
         end
      end
   end

   // stage 6: magnitudes, signs and the up-front overflow check
   logic [RW-1:0] dmag_in;
   logic [RW-1:0] rem_in [3];
   logic [QB-1:0] low_in [3];
   logic          neg_in [3];
   logic          ovf_in [3];

   always_comb begin
      logic [tpi_pkg::DEN_W-1:0]  dabs;
      logic [tpi_pkg::NUM_W-1:0]  nabs;
      logic [tpi_pkg::DIVD_W-1:0] sh;
      logic [tpi_pkg::HI_W-1:0]   hi;
      dabs    = den_ff[tpi_pkg::DEN_W-1] ? tpi_pkg::DEN_W'(-den_ff) : den_ff;
      dmag_in = dabs[RW-1:0];
      for (int k = 0; k < 3; k++) begin
         nabs = num_ff[k][tpi_pkg::NUM_W-1] ? tpi_pkg::NUM_W'(-num_ff[k]) : num_ff[k];
         sh   = {nabs[63:0], {tpi_pkg::NORMAL_FRAC_BITS{1'b0}}};
         hi   = sh[tpi_pkg::DIVD_W-1:QB];
         // quotient of 2^QB or more when the top part already reaches the divisor
         ovf_in[k] = tpi_pkg::DIVD_W'(hi) >= tpi_pkg::DIVD_W'(dmag_in);
         rem_in[k] = ovf_in[k] ? '0 : RW'(hi);
         low_in[k] = sh[QB-1:0];
         neg_in[k] = num_ff[k][tpi_pkg::NUM_W-1] == den_ff[tpi_pkg::DEN_W-1];
      end
   end

   // divider stages; index 0 is the stage 6 register
   logic          dv_v_ff   [QB+1];
   logic          found_ff  [QB+1];
   logic [RW-1:0] dmag_ff   [QB+1];
   logic [RW-1:0] rem_ff    [QB+1][3];
   logic [QB-1:0] low_ff    [QB+1][3];
   logic          neg_ff    [QB+1][3];
   logic          ovf_ff    [QB+1][3];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_v_ff[0] <= 1'b0;
      end else if (adv) begin
         dv_v_ff[0] <= s5_v_ff;
      end
      if (adv) begin
         found_ff[0] <= den_ff != '0;
         dmag_ff[0]  <= dmag_in;
         rem_ff[0]   <= rem_in;
         low_ff[0]   <= low_in;
         neg_ff[0]   <= neg_in;
         ovf_ff[0]   <= ovf_in;
      end
   end

   for (genvar i = 0; i < QB; i++) begin : g_div
      logic [RW-1:0] rem_n [3];
      logic [QB-1:0] low_n [3];

      always_comb begin
         logic [RW:0] t;
         logic        ge;
         for (int k = 0; k < 3; k++) begin
            t        = {rem_ff[i][k], low_ff[i][k][QB-1]};
            ge       = t >= {1'b0, dmag_ff[i]};
            rem_n[k] = ge ? RW'(t - {1'b0, dmag_ff[i]}) : t[RW-1:0];
            low_n[k] = {low_ff[i][k][QB-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[i+1] <= dv_v_ff[i];
         end
         if (adv) begin
            found_ff[i+1] <= found_ff[i];
            dmag_ff[i+1]  <= dmag_ff[i];
            rem_ff[i+1]   <= rem_n;
            low_ff[i+1]   <= low_n;
            neg_ff[i+1]   <= neg_ff[i];
            ovf_ff[i+1]   <= ovf_ff[i];
         end
      end
   end

   // saturation and result word
   always_comb begin
      logic [QB-1:0] q;
      logic [31:0]   c [3];
      logic          st [3];
      for (int k = 0; k < 3; k++) begin
         q = low_ff[QB][k];
         if (neg_ff[QB][k]) begin
            st[k] = ovf_ff[QB][k] || (|q[QB-1:32]) || (q[31] && (|q[30:0]));
            c[k]  = st[k] ? 32'h8000_0000 : 32'(-q[31:0]);
         end else begin
            st[k] = ovf_ff[QB][k] || (|q[QB-1:31]);
            c[k]  = st[k] ? 32'h7FFF_FFFF : q[31:0];
         end
      end
      out_in.found     = found_ff[QB];
      out_in.point_x   = found_ff[QB] ? c[0] : '0;
      out_in.point_y   = found_ff[QB] ? c[1] : '0;
      out_in.point_z   = found_ff[QB] ? c[2] : '0;
      out_in.saturated = found_ff[QB] && (st[0] || st[1] || st[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= dv_v_ff[QB];
      end
      if (adv) begin
         out_ff <= out_in;
      end
   end

endmodule
